/* hw/rtl/pafk_pkg.sv */
// ----------------------------------------------------------------------------
// pafk_pkg
// Shared widths, register indexes, arctangent table and clip helper for the
// planar arm forward kinematics pipeline.
// ----------------------------------------------------------------------------
package pafk_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int TRIG_W       = 34;
  localparam int TERM_W       = 30;
  localparam int SUM_W        = 35;
  localparam int LEN_W        = 24;
  localparam int COORD_W      = 32;
  localparam int ANG_W        = 16;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [58:0]       HALF_Q30    = 59'sd536870912;

  typedef enum logic [2:0] {
    REG_BASE_X      = 3'd0,
    REG_BASE_Y      = 3'd1,
    REG_BASE_HEAD   = 3'd2,
    REG_LEN_ONE     = 3'd3,
    REG_LEN_TWO     = 3'd4,
    REG_LEN_THREE   = 3'd5
  } reg_index_t;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1
  };

  typedef struct packed {
    logic [COORD_W-1:0] value;
    logic               clipped;
  } clip_t;

  function automatic clip_t clip32(input logic signed [SUM_W-1:0] v);
    clip_t r;
    if (v > $signed({{(SUM_W-COORD_W){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}})) begin
      r.value   = {1'b0, {(COORD_W-1){1'b1}}};
      r.clipped = 1'b1;
    end else if (v < $signed({{(SUM_W-COORD_W){1'b1}}, 1'b1, {(COORD_W-1){1'b0}}})) begin
      r.value   = {1'b1, {(COORD_W-1){1'b0}}};
      r.clipped = 1'b1;
    end else begin
      r.value   = v[COORD_W-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pafk_cordic.sv */
// ----------------------------------------------------------------------------
// pafk_cordic
// Rotation-mode cordic lane, one iteration per register stage, giving cos and
// sin in Q4.30 of a 16-bit binary angle.
// ----------------------------------------------------------------------------
module pafk_cordic (
  input  logic                                clk,
  input  logic [pafk_pkg::ANG_W-1:0]          angle,
  output logic signed [pafk_pkg::TRIG_W-1:0]  cos_out,
  output logic signed [pafk_pkg::TRIG_W-1:0]  sin_out
);

  localparam int N = pafk_pkg::CORDIC_STEPS;
  localparam int W = pafk_pkg::TRIG_W;

  logic signed [W-1:0] x [N+1];
  logic signed [W-1:0] y [N+1];
  logic signed [W-1:0] z [N+1];
  logic                flip [N+1];

  logic [31:0] theta;
  logic        quad_flip;

  always_comb begin
    theta     = {angle, 16'h0000};
    quad_flip = (theta[31:30] == 2'b01) || (theta[31:30] == 2'b10);
    if (quad_flip) begin
      theta = theta ^ 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    x[0]    <= pafk_pkg::CORDIC_GAIN;
    y[0]    <= '0;
    z[0]    <= {{(W-32){theta[31]}}, theta};
    flip[0] <= quad_flip;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [W-1:0] ATN = {{(W-32){1'b0}}, pafk_pkg::ATAN_TURN[i]};
    always_ff @(posedge clk) begin
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATN;
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATN;
      end
      flip[i+1] <= flip[i];
    end
  end

  always_ff @(posedge clk) begin
    if (flip[N]) begin
      cos_out <= -x[N];
      sin_out <= -y[N];
    end else begin
      cos_out <= x[N];
      sin_out <= y[N];
    end
  end

endmodule

/* hw/rtl/pafk_term.sv */
// ----------------------------------------------------------------------------
// pafk_term
// Link length times trig value, rounded half up to Q14.16, two stages.
// ----------------------------------------------------------------------------
module pafk_term (
  input  logic                                clk,
  input  logic [pafk_pkg::LEN_W-1:0]          len,
  input  logic signed [pafk_pkg::TRIG_W-1:0]  trig,
  output logic signed [pafk_pkg::TERM_W-1:0]  term
);

  logic signed [58:0] prod;
  logic signed [58:0] rnd;

  always_ff @(posedge clk) begin
    prod <= 59'($signed({1'b0, len}) * trig);
  end

  always_comb begin
    rnd = (prod + pafk_pkg::HALF_Q30) >>> 30;
  end

  always_ff @(posedge clk) begin
    term <= rnd[pafk_pkg::TERM_W-1:0];
  end

endmodule

/* hw/rtl/planar_arm_forward_kinematics_top.sv */
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics_top
// One item accepted every cycle. The path from start to done runs through the
// angle sum register, the 30-stage cordic lanes, then multiply, sum and clip.
// busy stays low; results cannot be held off and leave one per cycle.
// Synchronous reset clears the valid line and the configuration registers.
// ----------------------------------------------------------------------------
module planar_arm_forward_kinematics_top #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] joint_angle_a,
  input  logic signed [15:0] joint_angle_b,
  input  logic signed [15:0] joint_angle_c,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] elbow_one_x,
  output logic signed [31:0] elbow_one_y,
  output logic signed [31:0] elbow_two_x,
  output logic signed [31:0] elbow_two_y,
  output logic signed [31:0] tip_x,
  output logic signed [31:0] tip_y,
  output logic               saturated
);

  localparam int LAT  = 38;
  localparam int DROP = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
  localparam logic [15:0] ANG_MASK = 16'(16'hFFFF << DROP);
  localparam int SW = pafk_pkg::SUM_W;
  localparam int TW = pafk_pkg::TERM_W;

  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic [15:0]        base_heading;
  logic [23:0]        len_one;
  logic [23:0]        len_two;
  logic [23:0]        len_three;

  logic [LAT-1:0] vld;
  logic           accept;

  logic [15:0] t0, t1, t2;
  logic [15:0] t0_next, t1_next, t2_next;

  logic signed [pafk_pkg::TRIG_W-1:0] cs [3];
  logic signed [pafk_pkg::TRIG_W-1:0] sn [3];
  logic signed [TW-1:0] tx [3];
  logic signed [TW-1:0] ty [3];

  logic signed [SW-1:0] e1x, e1y, t2x, t2y, t23x, t23y;
  logic signed [SW-1:0] e1x_b, e1y_b, e2x, e2y, tpx, tpy;

  pafk_pkg::clip_t c1x, c1y, c2x, c2y, c3x, c3y;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x       <= '0;
      base_y       <= '0;
      base_heading <= '0;
      len_one      <= '0;
      len_two      <= '0;
      len_three    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pafk_pkg::REG_BASE_X:    base_x       <= cfg_data;
        pafk_pkg::REG_BASE_Y:    base_y       <= cfg_data;
        pafk_pkg::REG_BASE_HEAD: base_heading <= cfg_data[15:0];
        pafk_pkg::REG_LEN_ONE:   len_one      <= cfg_data[23:0];
        pafk_pkg::REG_LEN_TWO:   len_two      <= cfg_data[23:0];
        pafk_pkg::REG_LEN_THREE: len_three    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  always_comb begin
    t0_next = base_heading + joint_angle_a;
    t1_next = t0_next + joint_angle_b;
    t2_next = t1_next + joint_angle_c;
  end

  always_ff @(posedge clk) begin
    t0 <= t0_next & ANG_MASK;
    t1 <= t1_next & ANG_MASK;
    t2 <= t2_next & ANG_MASK;
  end

  pafk_cordic u_cordic0 (.clk(clk), .angle(t0), .cos_out(cs[0]), .sin_out(sn[0]));
  pafk_cordic u_cordic1 (.clk(clk), .angle(t1), .cos_out(cs[1]), .sin_out(sn[1]));
  pafk_cordic u_cordic2 (.clk(clk), .angle(t2), .cos_out(cs[2]), .sin_out(sn[2]));

  pafk_term u_term0x (.clk(clk), .len(len_one),   .trig(cs[0]), .term(tx[0]));
  pafk_term u_term0y (.clk(clk), .len(len_one),   .trig(sn[0]), .term(ty[0]));
  pafk_term u_term1x (.clk(clk), .len(len_two),   .trig(cs[1]), .term(tx[1]));
  pafk_term u_term1y (.clk(clk), .len(len_two),   .trig(sn[1]), .term(ty[1]));
  pafk_term u_term2x (.clk(clk), .len(len_three), .trig(cs[2]), .term(tx[2]));
  pafk_term u_term2y (.clk(clk), .len(len_three), .trig(sn[2]), .term(ty[2]));

  // first sum stage: elbow one and the pair of later terms
  always_ff @(posedge clk) begin
    e1x  <= SW'(base_x) + SW'(tx[0]);
    e1y  <= SW'(base_y) + SW'(ty[0]);
    t2x  <= SW'(tx[1]);
    t2y  <= SW'(ty[1]);
    t23x <= SW'(tx[1]) + SW'(tx[2]);
    t23y <= SW'(ty[1]) + SW'(ty[2]);
  end

  always_ff @(posedge clk) begin
    e1x_b <= e1x;
    e1y_b <= e1y;
    e2x   <= e1x + t2x;
    e2y   <= e1y + t2y;
    tpx   <= e1x + t23x;
    tpy   <= e1y + t23y;
  end

  always_comb begin
    c1x = pafk_pkg::clip32(e1x_b);
    c1y = pafk_pkg::clip32(e1y_b);
    c2x = pafk_pkg::clip32(e2x);
    c2y = pafk_pkg::clip32(e2y);
    c3x = pafk_pkg::clip32(tpx);
    c3y = pafk_pkg::clip32(tpy);
  end

  always_ff @(posedge clk) begin
    elbow_one_x <= c1x.value;
    elbow_one_y <= c1y.value;
    elbow_two_x <= c2x.value;
    elbow_two_y <= c2y.value;
    tip_x       <= c3x.value;
    tip_y       <= c3y.value;
    saturated   <= c1x.clipped | c1y.clipped | c2x.clipped | c2y.clipped |
                   c3x.clipped | c3y.clipped;
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives joint-angle items into the planar arm forward kinematics block under
// several arm set-ups, predicts each pose with a bit-exact cordic and
// link-accumulate model, and checks every result field in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [31:0] e1x, e1y, e2x, e2y, tx, ty;
    logic        sat;
  } pose_t;

  localparam longint GAIN_Q30  = 652032874;
  localparam longint ROUND_Q30 = 536870912;
  localparam int     QDEPTH    = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, saturated;
  logic signed [15:0] joint_angle_a = '0, joint_angle_b = '0, joint_angle_c = '0;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic signed [31:0] elbow_one_x, elbow_one_y, elbow_two_x, elbow_two_y, tip_x, tip_y;

  logic [31:0] arm_base_x, arm_base_y;
  logic [15:0] arm_heading;
  logic [23:0] arm_len [3];
  pose_t pose_buf [QDEPTH];
  int wr_count = 0;
  int rd_count = 0;
  int fail_count = 0;
  bit quiet = 0;

  planar_arm_forward_kinematics_top dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void cordic_trig(input logic [15:0] ang, output longint c,
                                      output longint s);
    logic [31:0] theta;
    longint z, x, y, xn;
    bit flip;
    theta = {ang, 16'h0};
    flip = (theta[31:30] == 2'b01) || (theta[31:30] == 2'b10);
    if (flip) theta ^= 32'h8000_0000;
    z = longint'(signed'(theta));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < pafk_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(pafk_pkg::ATAN_TURN[i]);
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(pafk_pkg::ATAN_TURN[i]);
      end
      x = xn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] clip_coord(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic pose_t predict_pose(input logic [15:0] a, b, c);
    pose_t p;
    logic [15:0] ang [3];
    longint px, py, co, si;
    logic [31:0] cx [3], cy [3];
    ang[0] = arm_heading + a;
    ang[1] = ang[0] + b;
    ang[2] = ang[1] + c;
    px = longint'(signed'(arm_base_x));
    py = longint'(signed'(arm_base_y));
    p.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      cordic_trig(ang[k], co, si);
      px += (longint'(arm_len[k]) * co + ROUND_Q30) >>> 30;
      py += (longint'(arm_len[k]) * si + ROUND_Q30) >>> 30;
      cx[k] = clip_coord(px, p.sat);
      cy[k] = clip_coord(py, p.sat);
    end
    p.e1x = cx[0]; p.e1y = cy[0];
    p.e2x = cx[1]; p.e2y = cy[1];
    p.tx  = cx[2]; p.ty  = cy[2];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t w;
    if (!rst && done) begin
      if (rd_count == wr_count) begin
        $display("%t unexpected result: expected none, actual tip %h %h", $time, tip_x, tip_y);
        fail_count++;
      end else begin
        w = pose_buf[rd_count % QDEPTH];
        rd_count++;
        if ({elbow_one_x, elbow_one_y, elbow_two_x, elbow_two_y, tip_x, tip_y, saturated} !==
            {w.e1x, w.e1y, w.e2x, w.e2y, w.tx, w.ty, w.sat}) begin
          $display("%t mismatch: expected %h %h %h %h %h %h sat %b", $time,
                   w.e1x, w.e1y, w.e2x, w.e2y, w.tx, w.ty, w.sat);
          $display("%t           actual   %h %h %h %h %h %h sat %b", $time,
                   elbow_one_x, elbow_one_y, elbow_two_x, elbow_two_y, tip_x, tip_y, saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [15:0] a, b, c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    joint_angle_a <= a;
    joint_angle_b <= b;
    joint_angle_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pose_buf[wr_count % QDEPTH] = predict_pose(a, b, c);
    wr_count++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (rd_count != wr_count) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      pafk_pkg::REG_BASE_X:    arm_base_x  = val;
      pafk_pkg::REG_BASE_Y:    arm_base_y  = val;
      pafk_pkg::REG_BASE_HEAD: arm_heading = val[15:0];
      pafk_pkg::REG_LEN_ONE:   arm_len[0]  = val[23:0];
      pafk_pkg::REG_LEN_TWO:   arm_len[1]  = val[23:0];
      pafk_pkg::REG_LEN_THREE: arm_len[2]  = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_arm(input logic [31:0] bx, by, input logic [15:0] hd,
                         input logic [23:0] l1, l2, l3);
    write_reg(pafk_pkg::REG_BASE_X, bx);
    write_reg(pafk_pkg::REG_BASE_Y, by);
    write_reg(pafk_pkg::REG_BASE_HEAD, {$urandom} & 32'hFFFF_0000 | hd);
    write_reg(pafk_pkg::REG_LEN_ONE, {$urandom} & 32'hFF00_0000 | l1);
    write_reg(pafk_pkg::REG_LEN_TWO, {$urandom} & 32'hFF00_0000 | l2);
    write_reg(pafk_pkg::REG_LEN_THREE, {$urandom} & 32'hFF00_0000 | l3);
  endtask

  task automatic test_reset_values;
    send_item(16'h1234, 16'h8000, 16'h7FFF);
    drain();
  endtask

  task automatic test_angle_extremes;
    set_arm(32'h0001_0000, 32'hFFFF_0000, 16'h4000, 24'h01_0000, 24'h02_8000, 24'hFF_FFFF);
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000, 16'h8000);
    send_item(16'hFFFF, 16'h0001, 16'hFFFF);
    send_item(16'hC000, 16'h4000, 16'h4000);
    send_item(16'h3FFF, 16'h4001, 16'hBFFF);
    send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_saturation;
    set_arm(32'h7FFF_0000, 32'h8000_0100, 16'h0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'h8000, 16'h0000, 16'h0000);
    send_item(16'hC000, 16'h0000, 16'h8000);
    send_item(16'h4000, 16'h8000, 16'h0000);
    drain();
    set_arm(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 24'hFF_FFFF, 24'h00_0000, 24'hFF_FFFF);
    send_item(16'h0000, 16'h1000, 16'h0000);
    send_item(16'hC000, 16'h0000, 16'h8000);
    send_item(16'h8000, 16'h8000, 16'h8000);
    drain();
  endtask

  task automatic test_unused_index;
    set_arm(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 24'h00_0001, 24'h10_0000, 24'h00_FFFF);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    send_item(16'h0001, 16'h2000, 16'hE000);
    send_item(16'h5555, 16'hAAAA, 16'h5555);
    drain();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: set_arm($urandom, $urandom, 16'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom));
        1: set_arm($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                   16'($urandom), 24'($urandom_range(0, 24'h0F_FFFF)),
                   24'($urandom_range(0, 24'h0F_FFFF)), 24'($urandom_range(0, 24'h0F_FFFF)));
        2: set_arm($urandom | 32'h7F00_0000, $urandom | 32'h8000_0000, 16'($urandom),
                   24'hFF_FFFF, 24'($urandom), 24'hFF_FFFF);
        default: set_arm($urandom, $urandom, 16'($urandom), 24'($urandom_range(0, 255)),
                         24'($urandom_range(0, 255)), 24'($urandom_range(0, 255)));
      endcase
      if (p == phases - 1) quiet = 1;
      repeat (per_phase) send_item(16'($urandom), 16'($urandom), 16'($urandom));
      drain();
    end
  endtask

  initial begin
    arm_base_x = '0; arm_base_y = '0; arm_heading = '0;
    arm_len[0] = '0; arm_len[1] = '0; arm_len[2] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_angle_extremes();
    test_saturation();
    test_unused_index();
    test_random(10, 143);
    repeat (45) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
